// ===== src/sidset_pkg.sv =====
// Shared types and field widths for the sorted ID set unit.
`timescale 1ns / 1ps
package sidset_pkg;

  localparam int OPC_W      = 3;
  localparam int ID_FIELD_W = 32;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;

  typedef enum logic [OPC_W-1:0] {
    OPC_APPEND = 3'd0,
    OPC_CLEAR  = 3'd1,
    OPC_ISECT  = 3'd2,
    OPC_UNION  = 3'd3,
    OPC_READ   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_CLEAR,
    CMD_READ,
    CMD_ISECT_EL,
    CMD_UNION_EL,
    CMD_ISECT_EMPTY,
    CMD_UNION_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [ID_FIELD_W-1:0]  id;
    logic [IDX_W-1:0]       ridx;
    logic                   last;
  } cmd_t;

endpackage

// ===== src/sidset_if.sv =====
// Request and result channel interfaces for the sorted ID set unit.
`timescale 1ns / 1ps
interface sidset_in_if;
  import sidset_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OPC_W-1:0]      opcode;
  logic [ID_FIELD_W-1:0] id_value;
  logic [IDX_W-1:0]      read_index;
  logic                  operand_last;
  logic                  operand_empty;
  modport source (output valid, opcode, id_value, read_index, operand_last,
                  operand_empty, input ready);
  modport sink (input valid, opcode, id_value, read_index, operand_last,
                operand_empty, output ready);
endinterface

interface sidset_out_if;
  import sidset_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ID_FIELD_W-1:0] read_value;
  logic [SIZE_W-1:0]     list_size;
  logic [SIZE_W-1:0]     changed_count;
  logic                  overflow;
  modport source (output valid, read_value, list_size, changed_count, overflow,
                  input ready);
  modport sink (input valid, read_value, list_size, changed_count, overflow,
                output ready);
endinterface

// ===== src/sidset_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module sidset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sidset_front.sv =====
// Front end: decodes requests into commands and queues them for the back end.
`timescale 1ns / 1ps
module sidset_front import sidset_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sidset_in_if.sink   in_ch,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        known;
  logic        push;
  cmd_t        dec;

  always_comb begin
    known    = 1'b1;
    dec.id   = in_ch.id_value;
    dec.ridx = in_ch.read_index;
    dec.last = in_ch.operand_last;
    dec.kind = CMD_CLEAR;
    unique case (in_ch.opcode)
      OPC_APPEND: dec.kind = CMD_APPEND;
      OPC_CLEAR:  dec.kind = CMD_CLEAR;
      OPC_READ:   dec.kind = CMD_READ;
      OPC_ISECT:  dec.kind = in_ch.operand_empty ? CMD_ISECT_EMPTY : CMD_ISECT_EL;
      OPC_UNION:  dec.kind = in_ch.operand_empty ? CMD_UNION_EMPTY : CMD_UNION_EL;
      default:    known = 1'b0;
    endcase
  end

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known;
  assign cmd_valid   = (fill != 2'd0);
  assign cmd         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== src/sidset_back.sv =====
// Back end: merge sequencer over the two list banks and the result register.
`timescale 1ns / 1ps
module sidset_back import sidset_pkg::*; #(
  parameter int LIST_DEPTH = 1024,
  parameter int ID_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  input  cmd_t         cmd,
  output logic         cmd_pop,
  sidset_out_if.source out_ch
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READW, ST_SCAN, ST_CMP, ST_TAIL, ST_TAILW, ST_COMMIT
  } state_t;
  typedef enum logic [1:0] {MODE_NONE, MODE_ISECT, MODE_UNION} mode_t;

  state_t              state;
  mode_t               op_mode;
  logic                active_bank;
  logic [CW-1:0]       stored_count;
  logic [CW-1:0]       scan_ptr;
  logic [CW-1:0]       fill_ptr;
  logic                ovf_seen;
  logic [ID_WIDTH-1:0] x;
  logic                x_last;

  logic [ID_WIDTH-1:0] rdata_a, rdata_b, rdata_cur;
  logic [AW-1:0]       rd_addr;
  logic                app_we, emit_req, emit_we;
  logic [ID_WIDTH-1:0] emit_data, cmd_id;
  logic                is_union;
  logic                ridx_ok;
  state_t              fin_state;

  assign rdata_cur = active_bank ? rdata_b : rdata_a;
  assign cmd_id    = ID_WIDTH'(cmd.id);
  assign is_union  = (op_mode == MODE_UNION);
  assign ridx_ok   = 32'(cmd.ridx) < 32'(stored_count);
  assign emit_we   = emit_req && (fill_ptr < DEPTH_C);
  assign fin_state = !x_last ? ST_IDLE : (is_union ? ST_TAIL : ST_COMMIT);

  always_comb begin
    cmd_pop   = 1'b0;
    app_we    = 1'b0;
    rd_addr   = '0;
    emit_req  = 1'b0;
    emit_data = x;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && !out_ch.valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_APPEND && stored_count < DEPTH_C) begin
            app_we = 1'b1;
          end
          if (ridx_ok) begin
            rd_addr = AW'(cmd.ridx);
          end
        end
      end
      ST_SCAN: begin
        if (scan_ptr < stored_count) begin
          rd_addr = AW'(scan_ptr);
        end else begin
          emit_req = is_union;
        end
      end
      ST_CMP: begin
        if (rdata_cur < x) begin
          emit_req  = is_union;
          emit_data = rdata_cur;
        end else if (rdata_cur == x) begin
          emit_req = 1'b1;
        end else begin
          emit_req = is_union;
        end
      end
      ST_TAIL: rd_addr = AW'(scan_ptr);
      ST_TAILW: begin
        emit_req  = 1'b1;
        emit_data = rdata_cur;
      end
      default: ;
    endcase
  end

  // Appends write the active bank, merge output goes to the other one.
  sidset_ram #(.WIDTH(ID_WIDTH), .DEPTH(LIST_DEPTH)) u_bank_a (
    .clk   (clk),
    .we    (active_bank ? emit_we : app_we),
    .waddr (active_bank ? AW'(fill_ptr) : AW'(stored_count)),
    .wdata (active_bank ? emit_data : cmd_id),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  sidset_ram #(.WIDTH(ID_WIDTH), .DEPTH(LIST_DEPTH)) u_bank_b (
    .clk   (clk),
    .we    (active_bank ? app_we : emit_we),
    .waddr (active_bank ? AW'(stored_count) : AW'(fill_ptr)),
    .wdata (active_bank ? cmd_id : emit_data),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op_mode      <= MODE_NONE;
      active_bank  <= 1'b0;
      stored_count <= '0;
      scan_ptr     <= '0;
      fill_ptr     <= '0;
      ovf_seen     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (emit_req) begin
        if (fill_ptr < DEPTH_C) begin
          fill_ptr <= fill_ptr + 1'b1;
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            out_ch.read_value    <= '0;
            out_ch.changed_count <= '0;
            out_ch.overflow      <= 1'b0;
            out_ch.list_size     <= SIZE_W'(stored_count);
            unique case (cmd.kind)
              CMD_APPEND, CMD_CLEAR, CMD_ISECT_EMPTY, CMD_UNION_EMPTY: begin
                op_mode  <= MODE_NONE;
                scan_ptr <= '0;
                fill_ptr <= '0;
                ovf_seen <= 1'b0;
                out_ch.valid <= 1'b1;
                if (cmd.kind == CMD_APPEND) begin
                  if (stored_count < DEPTH_C) begin
                    stored_count         <= stored_count + 1'b1;
                    out_ch.list_size     <= SIZE_W'(stored_count + 1'b1);
                    out_ch.changed_count <= SIZE_W'(1);
                  end else begin
                    out_ch.overflow <= 1'b1;
                  end
                end else if (cmd.kind == CMD_CLEAR) begin
                  stored_count     <= '0;
                  out_ch.list_size <= '0;
                end else if (cmd.kind == CMD_ISECT_EMPTY) begin
                  stored_count         <= '0;
                  out_ch.list_size     <= '0;
                  out_ch.changed_count <= SIZE_W'(stored_count);
                end
              end
              CMD_READ: state <= ST_READW;
              CMD_ISECT_EL, CMD_UNION_EL: begin
                if ((cmd.kind == CMD_UNION_EL) != is_union || op_mode == MODE_NONE) begin
                  scan_ptr <= '0;
                  fill_ptr <= '0;
                  ovf_seen <= 1'b0;
                end
                op_mode <= (cmd.kind == CMD_UNION_EL) ? MODE_UNION : MODE_ISECT;
                x       <= cmd_id;
                x_last  <= cmd.last;
                state   <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_READW: begin
          out_ch.read_value <= ID_FIELD_W'(rdata_cur);
          out_ch.valid      <= 1'b1;
          state             <= ST_IDLE;
        end
        ST_SCAN: state <= (scan_ptr < stored_count) ? ST_CMP : fin_state;
        ST_CMP: begin
          if (rdata_cur < x) begin
            scan_ptr <= scan_ptr + 1'b1;
            state    <= ST_SCAN;
          end else begin
            if (rdata_cur == x) begin
              scan_ptr <= scan_ptr + 1'b1;
            end
            state <= fin_state;
          end
        end
        ST_TAIL: state <= (scan_ptr < stored_count) ? ST_TAILW : ST_COMMIT;
        ST_TAILW: begin
          scan_ptr <= scan_ptr + 1'b1;
          state    <= ST_TAIL;
        end
        ST_COMMIT: begin
          active_bank          <= ~active_bank;
          stored_count         <= fill_ptr;
          out_ch.read_value    <= '0;
          out_ch.list_size     <= SIZE_W'(fill_ptr);
          out_ch.changed_count <= is_union ? SIZE_W'(fill_ptr - stored_count)
                                           : SIZE_W'(stored_count - fill_ptr);
          out_ch.overflow      <= is_union && ovf_seen;
          out_ch.valid         <= 1'b1;
          op_mode              <= MODE_NONE;
          scan_ptr             <= '0;
          fill_ptr             <= '0;
          ovf_seen             <= 1'b0;
          state                <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sorted_id_set_intersect_union_unit.sv =====
// Top level of the sorted ID set unit: front end, command queue and merge back end.
`timescale 1ns / 1ps
// The unit holds an ascending list of up to LIST_DEPTH IDs in two RAM banks and
// answers append, clear and read requests, and streaming intersect or union
// operands given one ID per request. A front end decodes requests into a
// two-entry queue, so the input side keeps taking requests while the back end
// works or a result waits, until the queue is full. Append, clear and
// empty-operand requests are answered straight from the idle state; a read
// passes through a wait state, as the bank read is registered. Each operand
// element does one bank read and one compare per stored ID it passes over, and
// a union's last element also copies the untouched stored tail. The merged
// list is written into the idle bank, which becomes active when the last
// element commits. The banks are not cleared after reset; reading an entry
// that was never written gives an undefined value.
module sorted_id_set_intersect_union_unit import sidset_pkg::*; #(
  parameter int LIST_DEPTH = 1024,
  parameter int ID_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst,
  sidset_in_if.sink    in_ch,
  sidset_out_if.source out_ch
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sidset_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sidset_back #(.LIST_DEPTH(LIST_DEPTH), .ID_WIDTH(ID_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/sidset_checker.sv =====
// Port-level checks for the sorted ID set unit, bound to the top level.
`timescale 1ns / 1ps
module sidset_checker import sidset_pkg::*; #(
  parameter int LIST_DEPTH = 1024
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SIZE_W-1:0] list_size,
  input logic              overflow
);

  // A waiting result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(list_size) <= LIST_DEPTH)
    else $error("list size beyond capacity");

  // IDs are only dropped when the list is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> 32'(list_size) == LIST_DEPTH)
    else $error("overflow reported with room left");

endmodule

bind sorted_id_set_intersect_union_unit sidset_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .list_size (out_ch.list_size),
  .overflow  (out_ch.overflow)
);
